// ===== design/bgt_pkg.sv =====
`default_nettype none

package bgt_pkg;

  // Ring of averaged samples.
  localparam int WINDOW_DEPTH = 8;
  localparam int SAMPLE_W     = 12;
  localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W        = SAMPLE_W + SLOT_W;

  // Configuration registers.
  localparam int RISE_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;

  localparam logic [SAMPLE_W-1:0] EMPTY_RESET = 12'd1862;
  localparam logic [SAMPLE_W-1:0] FULL_RESET  = 12'd2605;
  localparam logic [RISE_W-1:0]   RISE_RESET  = 8'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EMPTY = 2'd0,
    CFG_FULL  = 2'd1,
    CFG_RISE  = 2'd2
  } cfg_idx_e;

  // Percentage output.
  localparam int              PCT_W    = 7;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam int              PNUM_W   = SAMPLE_W + PCT_W;

  // Shared divider: two quotient bits per cycle.
  localparam int DIV_W    = 20;
  localparam int DSR_W    = 12;
  localparam int DIV_ITER = DIV_W / 2;
  localparam int CNT_W    = $clog2(DIV_ITER);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_AVG_START = 6'b000010,
    S_AVG_WAIT  = 6'b000100,
    S_PCT_START = 6'b001000,
    S_PCT_WAIT  = 6'b010000,
    S_DONE      = 6'b100000
  } state_e;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_sel_pct;
    logic avg_load;
    logic pct_load;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic sample_ok;
    logic div_done;
    logic pct_div;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== design/battery_level_and_charge_tracker.sv =====
// An accepted word's result is loaded into the output register after the average division and, when
// the average lies strictly between the empty and full levels, the percentage division; a clamped
// percentage skips the second and an invalid sample both. The shared two-bit-per-cycle divider
// runs both divisions, and no new sample is taken until the last one's result is loaded, which
// waits while a held output word is stalled.
// Reset clears the ring, fill count, previous average and flag at once and loads the
// default levels; no clearing pass is needed and a sample may be taken straight away.
`default_nettype none

module battery_level_and_charge_tracker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [bgt_pkg::SAMPLE_W-1:0]    sample_i,
  input  wire logic                            sample_valid_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [bgt_pkg::PCT_W-1:0]            percent_o,
  output logic                                 charging_o,
  output logic [bgt_pkg::SAMPLE_W-1:0]         average_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [bgt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [bgt_pkg::CFG_DAT_W-1:0]   cfg_data_i
);

  bgt_pkg::cmd_t    cmd;
  bgt_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  bgt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bgt_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .sample_i       (sample_i),
    .sample_valid_i (sample_valid_i),
    .cfg_we_i       (cfg_valid_i & cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .percent_o      (percent_o),
    .charging_o     (charging_o),
    .average_o      (average_o)
  );

endmodule

`default_nettype wire

// ===== design/bgt_div.sv =====
`default_nettype none

module bgt_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [bgt_pkg::DIV_W-1:0]   dividend_i,
  input  wire logic [bgt_pkg::DSR_W-1:0]   divisor_i,
  output logic                             done_o,
  output logic [bgt_pkg::DIV_W-1:0]        quotient_o
);

  logic                        run_q, run_d;
  logic                        done_q, done_d;
  logic [bgt_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [bgt_pkg::DIV_W-1:0]   dvd_q, dvd_d;
  logic [bgt_pkg::DSR_W-1:0]   rem_q, rem_d;
  logic [bgt_pkg::DSR_W-1:0]   dsr_q, dsr_d;

  logic [bgt_pkg::DSR_W-1:0]   r;
  logic [bgt_pkg::DIV_W-1:0]   q;
  logic [bgt_pkg::DSR_W:0]     t;

  // Two restoring steps per cycle; the dividend register fills with quotient bits.
  always_comb begin
    r = rem_q;
    q = dvd_q;
    t = '0;
    for (int k = 0; k < 2; k++) begin
      t = {r, q[bgt_pkg::DIV_W-1]};
      q = {q[bgt_pkg::DIV_W-2:0], 1'b0};
      if (t >= {1'b0, dsr_q}) begin
        t    = t - {1'b0, dsr_q};
        q[0] = 1'b1;
      end
      r = t[bgt_pkg::DSR_W-1:0];
    end
  end

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      dvd_d = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
    end else if (run_q) begin
      dvd_d = q;
      rem_d = r;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == bgt_pkg::CNT_W'(bgt_pkg::DIV_ITER - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

  a_done_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##(bgt_pkg::DIV_ITER + 1) done_q)
    else $error("divider did not finish after the expected number of cycles");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !run_q)
    else $error("divider flagged done while still iterating");

endmodule

`default_nettype wire

// ===== design/bgt_datapath.sv =====
`default_nettype none

module bgt_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire bgt_pkg::cmd_t                   cmd_i,
  output bgt_pkg::status_t                     status_o,
  input  wire logic [bgt_pkg::SAMPLE_W-1:0]    sample_i,
  input  wire logic                            sample_valid_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [bgt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [bgt_pkg::CFG_DAT_W-1:0]   cfg_data_i,
  input  wire logic                            out_stall_i,
  output logic                                 out_valid_o,
  output logic [bgt_pkg::PCT_W-1:0]            percent_o,
  output logic                                 charging_o,
  output logic [bgt_pkg::SAMPLE_W-1:0]         average_o
);

  logic [bgt_pkg::SAMPLE_W-1:0] empty_q, full_q;
  logic [bgt_pkg::RISE_W-1:0]   rise_q;

  logic [bgt_pkg::SAMPLE_W-1:0] window_q [bgt_pkg::WINDOW_DEPTH];
  logic [bgt_pkg::SLOT_W-1:0]   slot_q, slot_d;
  logic [bgt_pkg::FILL_W-1:0]   fill_q, fill_d;
  logic [bgt_pkg::SUM_W-1:0]    sum_q, sum_d;
  logic [bgt_pkg::SAMPLE_W-1:0] prev_q;
  logic                         flag_q, flag_d;

  logic [bgt_pkg::PCT_W-1:0]    res_pct_q;
  logic                         res_chg_q;
  logic [bgt_pkg::SAMPLE_W-1:0] res_avg_q;

  logic                         out_valid_q, out_valid_d;
  logic [bgt_pkg::PCT_W-1:0]    percent_q;
  logic                         charging_q;
  logic [bgt_pkg::SAMPLE_W-1:0] average_q;

  logic                         ring_we;
  logic                         div_done;
  logic [bgt_pkg::DIV_W-1:0]    quotient;
  logic [bgt_pkg::DIV_W-1:0]    div_dividend;
  logic [bgt_pkg::DSR_W-1:0]    div_divisor;
  logic [bgt_pkg::SAMPLE_W-1:0] avg_new;
  logic [bgt_pkg::SAMPLE_W:0]   rise_lim;
  logic [bgt_pkg::SAMPLE_W-1:0] span_num;
  logic [bgt_pkg::PNUM_W-1:0]   pct_num;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q <= bgt_pkg::EMPTY_RESET;
      full_q  <= bgt_pkg::FULL_RESET;
      rise_q  <= bgt_pkg::RISE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bgt_pkg::CFG_EMPTY: empty_q <= cfg_data_i[bgt_pkg::SAMPLE_W-1:0];
        bgt_pkg::CFG_FULL:  full_q  <= cfg_data_i[bgt_pkg::SAMPLE_W-1:0];
        bgt_pkg::CFG_RISE:  rise_q  <= cfg_data_i[bgt_pkg::RISE_W-1:0];
        default: ;
      endcase
    end
  end

  // Unfilled slots hold zero, so the running sum over all slots is the sum of the filled ones.
  assign ring_we = cmd_i.accept & sample_valid_i;
  assign slot_d  = (slot_q == bgt_pkg::SLOT_W'(bgt_pkg::WINDOW_DEPTH - 1)) ? '0
                                                                            : slot_q + 1'b1;
  assign fill_d  = (fill_q == bgt_pkg::FILL_W'(bgt_pkg::WINDOW_DEPTH)) ? fill_q
                                                                        : fill_q + 1'b1;
  assign sum_d   = sum_q - bgt_pkg::SUM_W'(window_q[slot_q]) + bgt_pkg::SUM_W'(sample_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bgt_pkg::WINDOW_DEPTH; i++) begin
        window_q[i] <= '0;
      end
      slot_q <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else if (ring_we) begin
      window_q[slot_q] <= sample_i;
      slot_q           <= slot_d;
      fill_q           <= fill_d;
      sum_q            <= sum_d;
    end
  end

  // The percentage numerator uses the average registered by the previous division.
  assign span_num = res_avg_q - empty_q;
  assign pct_num  = bgt_pkg::PNUM_W'(span_num) * bgt_pkg::PNUM_W'(bgt_pkg::PCT_FULL);

  always_comb begin
    if (cmd_i.div_sel_pct) begin
      div_dividend = bgt_pkg::DIV_W'(pct_num);
      div_divisor  = full_q - empty_q;
    end else begin
      div_dividend = bgt_pkg::DIV_W'(sum_q);
      div_divisor  = bgt_pkg::DSR_W'(fill_q);
    end
  end

  bgt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign avg_new  = quotient[bgt_pkg::SAMPLE_W-1:0];
  assign rise_lim = {1'b0, prev_q} + (bgt_pkg::SAMPLE_W + 1)'(rise_q);

  // A zero previous average can never set the flag, but a fall still clears it.
  always_comb begin
    flag_d = flag_q;
    if ((prev_q != '0) && ({1'b0, avg_new} > rise_lim)) begin
      flag_d = 1'b1;
    end else if (avg_new < prev_q) begin
      flag_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      flag_q <= 1'b0;
    end else if (cmd_i.avg_load) begin
      prev_q <= avg_new;
      flag_q <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && !sample_valid_i) begin
      res_pct_q <= bgt_pkg::PCT_FULL;
      res_chg_q <= 1'b0;
      res_avg_q <= '0;
    end else if (cmd_i.avg_load) begin
      res_chg_q <= flag_d;
      res_avg_q <= avg_new;
      if (avg_new <= empty_q) begin
        res_pct_q <= '0;
      end else if (avg_new >= full_q) begin
        res_pct_q <= bgt_pkg::PCT_FULL;
      end
    end else if (cmd_i.pct_load) begin
      res_pct_q <= quotient[bgt_pkg::PCT_W-1:0];
    end
  end

  // Output register: a finished word waits here while the next sample is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      percent_q  <= res_pct_q;
      charging_q <= res_chg_q;
      average_q  <= res_avg_q;
    end
  end

  assign status_o.sample_ok = sample_valid_i;
  assign status_o.div_done  = div_done;
  assign status_o.pct_div   = (avg_new > empty_q) && (avg_new < full_q);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign percent_o   = percent_q;
  assign charging_o  = charging_q;
  assign average_o   = average_q;

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_q)
    else $error("loaded result word not presented");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_we && (fill_q != bgt_pkg::FILL_W'(bgt_pkg::WINDOW_DEPTH))
    |=> fill_q == $past(fill_q) + 1'b1)
    else $error("fill count did not advance on a valid sample");

endmodule

`default_nettype wire

// ===== design/bgt_ctrl.sv =====
`default_nettype none

module bgt_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire bgt_pkg::status_t status_i,
  output bgt_pkg::cmd_t         cmd_o
);

  bgt_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      bgt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = status_i.sample_ok ? bgt_pkg::S_AVG_START : bgt_pkg::S_DONE;
        end
      end
      bgt_pkg::S_AVG_START: begin
        cmd_o.div_start = 1'b1;
        state_d = bgt_pkg::S_AVG_WAIT;
      end
      bgt_pkg::S_AVG_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.avg_load = 1'b1;
          state_d = status_i.pct_div ? bgt_pkg::S_PCT_START : bgt_pkg::S_DONE;
        end
      end
      bgt_pkg::S_PCT_START: begin
        cmd_o.div_start   = 1'b1;
        cmd_o.div_sel_pct = 1'b1;
        state_d = bgt_pkg::S_PCT_WAIT;
      end
      bgt_pkg::S_PCT_WAIT: begin
        cmd_o.div_sel_pct = 1'b1;
        if (status_i.div_done) begin
          cmd_o.pct_load = 1'b1;
          state_d = bgt_pkg::S_DONE;
        end
      end
      bgt_pkg::S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = bgt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bgt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bgt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != bgt_pkg::S_IDLE);

endmodule

`default_nettype wire
